// ===== sv/dbm_pkg.sv =====
`default_nettype none

package dbm_pkg;

    localparam int SENSOR_COUNT  = 2;
    localparam int CORDIC_STEPS  = 24;
    localparam int QUOT_BITS     = 33;
    localparam int Z_W           = 28;
    localparam int ALIGN_DELAY   = QUOT_BITS - CORDIC_STEPS;
    // front end (3) + divider cells + output register
    localparam int PIPE_DEPTH    = 3 + QUOT_BITS + 1;

    localparam logic signed [Z_W-1:0] HALF_PI_Z     = 28'sd26353589;
    localparam logic signed [16:0]    BEARING_LIMIT = 17'sd25736;
    localparam logic signed [Z_W-1:0] ROUND_HALF    = 28'sd1024;

    typedef enum logic [1:0] {
        REG_SENSOR_ONE_X = 2'd0,
        REG_SENSOR_ONE_Y = 2'd1,
        REG_SENSOR_TWO_X = 2'd2,
        REG_SENSOR_TWO_Y = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
    } target_t;

    typedef struct packed {
        logic signed [15:0] bearing_one;
        logic signed [15:0] bearing_two;
        logic signed [31:0] slope_one_x;
        logic signed [31:0] slope_one_y;
        logic signed [31:0] slope_two_x;
        logic signed [31:0] slope_two_y;
        logic               degenerate_one;
        logic               degenerate_two;
    } result_t;

    typedef struct packed {
        logic signed [63:0]    x;
        logic signed [63:0]    y;
        logic signed [Z_W-1:0] z;
    } cordic_t;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic kill;
        logic degen;
    } div_side_t;

    typedef struct packed {
        logic [63:0]          rem_a;
        logic [63:0]          rem_b;
        logic [63:0]          divisor;
        logic [QUOT_BITS-1:0] q_a;
        logic [QUOT_BITS-1:0] q_b;
        div_side_t            side;
    } div_t;

    typedef struct packed {
        logic signed [15:0] bearing;
        logic signed [31:0] slope_x;
        logic signed [31:0] slope_y;
        logic               degenerate;
    } lane_out_t;

    // arctangent of 2^-i in units of 2^-24 rad
    function automatic logic signed [Z_W-1:0] atan_lut(input logic [4:0] idx);
        logic signed [Z_W-1:0] v;
        begin
            case (idx)
                5'd0:    v = 28'sd13176795;
                5'd1:    v = 28'sd7778716;
                5'd2:    v = 28'sd4110060;
                5'd3:    v = 28'sd2086331;
                5'd4:    v = 28'sd1047214;
                5'd5:    v = 28'sd524117;
                5'd6:    v = 28'sd262123;
                5'd7:    v = 28'sd131069;
                5'd8:    v = 28'sd65536;
                5'd9:    v = 28'sd32768;
                5'd10:   v = 28'sd16384;
                5'd11:   v = 28'sd8192;
                5'd12:   v = 28'sd4096;
                5'd13:   v = 28'sd2048;
                5'd14:   v = 28'sd1024;
                5'd15:   v = 28'sd512;
                5'd16:   v = 28'sd256;
                5'd17:   v = 28'sd128;
                5'd18:   v = 28'sd64;
                5'd19:   v = 28'sd32;
                5'd20:   v = 28'sd16;
                5'd21:   v = 28'sd8;
                5'd22:   v = 28'sd4;
                5'd23:   v = 28'sd2;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // apply sign to a truncated quotient and saturate to 32 bits
    function automatic logic [31:0] sat_slope(input logic [QUOT_BITS-1:0] q,
                                              input logic neg);
        logic [31:0] v;
        begin
            if (neg)
            begin
                if (q > 33'h080000000)
                    v = 32'h80000000;
                else
                    v = 32'd0 - q[31:0];
            end
            else
            begin
                if (q > 33'h07FFFFFFF)
                    v = 32'h7FFFFFFF;
                else
                    v = q[31:0];
            end
            return v;
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/dbm_cordic_cell.sv =====
`default_nettype none

module dbm_cordic_cell
    import dbm_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  wire logic    clk,
    input  wire cordic_t vec_in,
    output cordic_t      vec_out
);

    cordic_t vec_reg;
    cordic_t vec_next;
    logic signed [63:0] xs;
    logic signed [63:0] ys;

    always_comb
    begin
        xs = vec_in.x >>> STEP;
        ys = vec_in.y >>> STEP;
        // zero y takes the counterclockwise branch
        if (vec_in.y > 64'sd0)
        begin
            vec_next.x = vec_in.x + ys;
            vec_next.y = vec_in.y - xs;
            vec_next.z = vec_in.z + atan_lut(5'(STEP));
        end
        else
        begin
            vec_next.x = vec_in.x - ys;
            vec_next.y = vec_in.y + xs;
            vec_next.z = vec_in.z - atan_lut(5'(STEP));
        end
    end

    always_ff @(posedge clk)
    begin
        vec_reg <= vec_next;
    end

    assign vec_out = vec_reg;

endmodule

`default_nettype wire

// ===== sv/dbm_div_cell.sv =====
`default_nettype none

module dbm_div_cell
    import dbm_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  wire logic clk,
    input  wire div_t div_in,
    output div_t      div_out
);

    div_t div_reg;
    div_t div_next;

    // one restoring step for both numerators against the shared divisor
    always_comb
    begin
        div_next = div_in;
        if ((div_in.rem_a >> BIT) >= div_in.divisor)
        begin
            div_next.rem_a  = div_in.rem_a - (div_in.divisor << BIT);
            div_next.q_a[BIT] = 1'b1;
        end
        if ((div_in.rem_b >> BIT) >= div_in.divisor)
        begin
            div_next.rem_b  = div_in.rem_b - (div_in.divisor << BIT);
            div_next.q_b[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
    end

    assign div_out = div_reg;

endmodule

`default_nettype wire

// ===== sv/dbm_lane.sv =====
`default_nettype none

module dbm_lane
    import dbm_pkg::*;
(
    input  wire logic         clk,
    input  wire target_t      target_in,
    input  wire logic [31:0]  sensor_x,
    input  wire logic [31:0]  sensor_y,
    output lane_out_t         lane_out
);

    // stage a: offsets
    logic signed [32:0] dx_a_reg, dy_a_reg;
    // stage b: squares
    logic signed [32:0] dx_b_reg, dy_b_reg;
    logic [31:0]        ax_b_reg, ay_b_reg;
    logic [63:0]        sqx_b_reg, sqy_b_reg;
    logic [31:0]        ax_b_next, ay_b_next;
    // stage c: range squared
    logic signed [32:0] dx_c_reg, dy_c_reg;
    logic [31:0]        ax_c_reg, ay_c_reg;
    logic [63:0]        r2_c_reg;
    logic               big_c_reg, degen_c_reg;
    logic [64:0]        r2_c_next;

    cordic_t               cv [CORDIC_STEPS+1];
    div_t                  dv [QUOT_BITS+1];
    logic signed [Z_W-1:0] z_dly_reg [ALIGN_DELAY];

    lane_out_t             out_reg;
    lane_out_t             out_next;
    logic signed [63:0]    x0, y0;
    logic signed [Z_W-1:0] z_round;
    logic signed [16:0]    z_q13;
    logic signed [15:0]    bearing_c;

    always_ff @(posedge clk)
    begin
        dx_a_reg <= {target_in.target_x[31], target_in.target_x} - {sensor_x[31], sensor_x};
        dy_a_reg <= {target_in.target_y[31], target_in.target_y} - {sensor_y[31], sensor_y};
    end

    assign ax_b_next = dx_a_reg[32] ? 32'(-dx_a_reg) : dx_a_reg[31:0];
    assign ay_b_next = dy_a_reg[32] ? 32'(-dy_a_reg) : dy_a_reg[31:0];

    always_ff @(posedge clk)
    begin
        dx_b_reg  <= dx_a_reg;
        dy_b_reg  <= dy_a_reg;
        ax_b_reg  <= ax_b_next;
        ay_b_reg  <= ay_b_next;
        sqx_b_reg <= 64'(ax_b_next) * 64'(ax_b_next);
        sqy_b_reg <= 64'(ay_b_next) * 64'(ay_b_next);
    end

    assign r2_c_next = {1'b0, sqx_b_reg} + {1'b0, sqy_b_reg};

    always_ff @(posedge clk)
    begin
        dx_c_reg    <= dx_b_reg;
        dy_c_reg    <= dy_b_reg;
        ax_c_reg    <= ax_b_reg;
        ay_c_reg    <= ay_b_reg;
        r2_c_reg    <= r2_c_next[63:0];
        big_c_reg   <= r2_c_next[64];
        degen_c_reg <= (dx_b_reg == 33'sd0) && (dy_b_reg == 33'sd0);
    end

    // quarter-turn pre-rotation into the right half plane
    always_comb
    begin
        x0 = {{3{dx_c_reg[32]}}, dx_c_reg, 28'b0};
        y0 = {{3{dy_c_reg[32]}}, dy_c_reg, 28'b0};
        cv[0].x = x0;
        cv[0].y = y0;
        cv[0].z = '0;
        if (dx_c_reg[32])
        begin
            if (!dy_c_reg[32])
            begin
                cv[0].x = y0;
                cv[0].y = -x0;
                cv[0].z = HALF_PI_Z;
            end
            else
            begin
                cv[0].x = -y0;
                cv[0].y = x0;
                cv[0].z = -HALF_PI_Z;
            end
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cordic
        dbm_cordic_cell #(.STEP(k)) u_cell
        (
            .clk     (clk),
            .vec_in  (cv[k]),
            .vec_out (cv[k+1])
        );
    end

    // bring the angle level with the divider chain
    always_ff @(posedge clk)
    begin
        z_dly_reg[0] <= cv[CORDIC_STEPS].z;
        for (int i = 1; i < ALIGN_DELAY; i++)
        begin
            z_dly_reg[i] <= z_dly_reg[i-1];
        end
    end

    always_comb
    begin
        dv[0].rem_a      = {ay_c_reg, 32'b0};
        dv[0].rem_b      = {ax_c_reg, 32'b0};
        dv[0].divisor    = r2_c_reg;
        dv[0].q_a        = '0;
        dv[0].q_b        = '0;
        dv[0].side.neg_x = !dy_c_reg[32] && (dy_c_reg != 33'sd0);
        dv[0].side.neg_y = dx_c_reg[32];
        dv[0].side.kill  = big_c_reg || degen_c_reg;
        dv[0].side.degen = degen_c_reg;
    end

    for (genvar k = 0; k < QUOT_BITS; k++)
    begin : g_div
        dbm_div_cell #(.BIT(QUOT_BITS - 1 - k)) u_cell
        (
            .clk     (clk),
            .div_in  (dv[k]),
            .div_out (dv[k+1])
        );
    end

    always_comb
    begin
        z_round = z_dly_reg[ALIGN_DELAY-1] + ROUND_HALF;
        z_q13   = 17'(z_round >>> 11);
        if (z_q13 > BEARING_LIMIT)
            bearing_c = 16'(BEARING_LIMIT);
        else if (z_q13 < -BEARING_LIMIT)
            bearing_c = 16'(-BEARING_LIMIT);
        else
            bearing_c = z_q13[15:0];

        out_next.degenerate = dv[QUOT_BITS].side.degen;
        out_next.bearing    = dv[QUOT_BITS].side.degen ? 16'sd0 : bearing_c;
        if (dv[QUOT_BITS].side.kill)
        begin
            out_next.slope_x = '0;
            out_next.slope_y = '0;
        end
        else
        begin
            out_next.slope_x = sat_slope(dv[QUOT_BITS].q_a, dv[QUOT_BITS].side.neg_x);
            out_next.slope_y = sat_slope(dv[QUOT_BITS].q_b, dv[QUOT_BITS].side.neg_y);
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign lane_out = out_reg;

endmodule

`default_nettype wire

// ===== sv/dual_bearing_measurement.sv =====
// channel   direction  handshake        payload
// target    in         start, busy      target_t  (target_x, target_y)
// result    out        done strobe      result_t  (bearings, slopes, flags)
// config    in         wr_en            wr_index, wr_data (sensor positions)
//
// one target transfer per cycle; busy is never raised
// each result passes through three front-end stages, the 33-cell divider row
// and one output register
// reset clears the sensor registers and the in-flight valid bits
// the receiver cannot stall: done is a one-cycle strobe
`default_nettype none

module dual_bearing_measurement
    import dbm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire target_t     target,
    output logic             done,
    output result_t          result,
    input  wire logic        wr_en,
    input  wire logic [1:0]  wr_index,
    input  wire logic [31:0] wr_data
);

    logic [31:0]           sensor_x_reg [SENSOR_COUNT];
    logic [31:0]           sensor_y_reg [SENSOR_COUNT];
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    lane_out_t             lane_res [SENSOR_COUNT];

    // pipeline never holds off a transfer
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SENSOR_COUNT; i++)
            begin
                sensor_x_reg[i] <= '0;
                sensor_y_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            case (cfg_reg_t'(wr_index))
                REG_SENSOR_ONE_X: sensor_x_reg[0] <= wr_data;
                REG_SENSOR_ONE_Y: sensor_y_reg[0] <= wr_data;
                REG_SENSOR_TWO_X: sensor_x_reg[1] <= wr_data;
                REG_SENSOR_TWO_Y: sensor_y_reg[1] <= wr_data;
                default: ;
            endcase
        end
    end

    // valid bits walk alongside the free-running payload cells
    assign valid_next = {valid_reg[PIPE_DEPTH-2:0], start && !busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    for (genvar s = 0; s < SENSOR_COUNT; s++)
    begin : g_lane
        dbm_lane u_lane
        (
            .clk       (clk),
            .target_in (target),
            .sensor_x  (sensor_x_reg[s]),
            .sensor_y  (sensor_y_reg[s]),
            .lane_out  (lane_res[s])
        );
    end

    assign done = valid_reg[PIPE_DEPTH-1];

    always_comb
    begin
        result.bearing_one    = lane_res[0].bearing;
        result.bearing_two    = lane_res[1].bearing;
        result.slope_one_x    = lane_res[0].slope_x;
        result.slope_one_y    = lane_res[0].slope_y;
        result.slope_two_x    = lane_res[1].slope_x;
        result.slope_two_y    = lane_res[1].slope_y;
        result.degenerate_one = lane_res[0].degenerate;
        result.degenerate_two = lane_res[1].degenerate;
    end

`ifndef ASSERT_OFF
    a_done_follows_chain: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[PIPE_DEPTH-2] |=> done)
        else $error("valid bit lost in the pipeline");

    a_degen_one_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.degenerate_one |-> result.bearing_one == 16'sd0
            && result.slope_one_x == 32'sd0 && result.slope_one_y == 32'sd0)
        else $error("coincident first sensor gave nonzero outputs");

    a_degen_two_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.degenerate_two |-> result.bearing_two == 16'sd0
            && result.slope_two_x == 32'sd0 && result.slope_two_y == 32'sd0)
        else $error("coincident second sensor gave nonzero outputs");

    a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.bearing_one <= 16'sd25736 && result.bearing_one >= -16'sd25736
            && result.bearing_two <= 16'sd25736 && result.bearing_two >= -16'sd25736)
        else $error("bearing outside clamp range");
`endif

endmodule

`default_nettype wire
